/* rtl/core/u2a_pkg.sv */
// Package for the unsigned-to-ASCII converter: controller/datapath
// interface types, state encoding, character constants and the hex glyph function.
// No dependencies.
`default_nettype none

package u2a_pkg;

  localparam int unsigned NumDigits = 10;   // decimal digits of a 32-bit value
  localparam int unsigned HexDigits = 8;    // hex digits of a 32-bit value
  localparam int unsigned ValueW    = 32;
  localparam int unsigned CharW     = 7;
  localparam int unsigned CntW      = 5;    // holds ValueW - 1

  localparam logic [CharW-1:0] CHAR_ZERO = 7'h30;  // '0'
  localparam logic [CharW-1:0] CHAR_X    = 7'h78;  // 'x'
  localparam logic [CharW-1:0] CHAR_A    = 7'h61;  // 'a'

  localparam logic [CntW-1:0] DABBLE_START = CntW'(ValueW - 1);
  localparam logic [CntW-1:0] DEC_START    = CntW'(NumDigits - 1);
  localparam logic [CntW-1:0] HEX_START    = CntW'(HexDigits - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_PFX_ZERO,
    ST_PFX_X,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;      // capture a new input beat
    logic dabble;    // one shift-add-3 step
    logic put_zero;  // emit the '0' of the hex prefix
    logic put_x;     // emit the 'x' of the hex prefix
    logic advance;   // consume the top digit, emitting it unless it is a decimal leading zero
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;  // step counter reached its final position
    logic out_free;  // output register can take a character this cycle
  } status_t;

  function automatic logic [CharW-1:0] hex_glyph(input logic [3:0] n);
    logic [CharW-1:0] r;
    if (n < 4'd10) begin
      r = CHAR_ZERO + {3'b000, n};
    end else begin
      r = CHAR_A + {3'b000, n} - 7'd10;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/u2a_dp.sv */
// Datapath of the unsigned-to-ASCII converter: binary-to-BCD shift register,
// step counter and output register. Depends on u2a_pkg.
`default_nettype none

module u2a_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [31:0]                value,
  input  wire logic                       kind,
  input  wire u2a_pkg::cmd_t              cmd,
  output      u2a_pkg::status_t           status,
  output      logic [6:0]                 character,
  output      logic                       last,
  output      logic                       char_valid,
  input  wire logic                       char_ready
);
  import u2a_pkg::*;

  logic [4*NumDigits-1:0] dig;
  logic [ValueW-1:0]      bin;
  logic [CntW-1:0]        cnt;
  logic                   hex;
  logic                   started;

  logic [4*NumDigits-1:0] dig_adj;
  logic [3:0]             top;
  logic                   out_free;
  logic                   show;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (dig[4*i +: 4] >= 4'd5) begin
        dig_adj[4*i +: 4] = dig[4*i +: 4] + 4'd3;
      end else begin
        dig_adj[4*i +: 4] = dig[4*i +: 4];
      end
    end
  end

  assign top      = dig[4*NumDigits-1 -: 4];
  assign out_free = !char_valid || char_ready;
  // Leading zeros are dropped in decimal, but the units digit always shows.
  assign show     = hex || started || (top != 4'd0) || (cnt == '0);

  assign status.cnt_zero = (cnt == '0);
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin     <= value;
      hex     <= kind;
      started <= 1'b0;
      if (kind) begin
        dig <= {value, 8'h00};
        cnt <= HEX_START;
      end else begin
        dig <= '0;
        cnt <= DABBLE_START;
      end
    end else if (cmd.dabble) begin
      {dig, bin} <= {dig_adj[4*NumDigits-2:0], bin, 1'b0};
      cnt        <= (cnt == '0) ? DEC_START : cnt - 1'b1;
    end else if (cmd.advance) begin
      dig     <= {dig[4*NumDigits-5:0], 4'h0};
      cnt     <= cnt - 1'b1;
      started <= started || (top != 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (cmd.put_zero || cmd.put_x || (cmd.advance && show)) begin
      char_valid <= 1'b1;
    end else if (char_ready) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_zero) begin
      character <= CHAR_ZERO;
      last      <= 1'b0;
    end else if (cmd.put_x) begin
      character <= CHAR_X;
      last      <= 1'b0;
    end else if (cmd.advance && show) begin
      character <= hex_glyph(top);
      last      <= (cnt == '0);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/u2a_ctrl.sv */
// Controller of the unsigned-to-ASCII converter: sequences conversion,
// prefix and digit emission. Depends on u2a_pkg.
`default_nettype none

module u2a_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output      logic             item_ready,
  input  wire logic             kind,
  input  wire u2a_pkg::status_t status,
  output      u2a_pkg::cmd_t    cmd
);
  import u2a_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = kind ? ST_PFX_ZERO : ST_DABBLE;
        end
      end
      ST_DABBLE: begin
        if (status.cnt_zero) begin
          state_next = ST_EMIT;
        end
      end
      ST_PFX_ZERO: begin
        if (status.out_free) begin
          state_next = ST_PFX_X;
        end
      end
      ST_PFX_X: begin
        if (status.out_free) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free && status.cnt_zero) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      ST_DABBLE:   cmd.dabble   = 1'b1;
      ST_PFX_ZERO: cmd.put_zero = status.out_free;
      ST_PFX_X:    cmd.put_x    = status.out_free;
      ST_EMIT:     cmd.advance  = status.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/unsigned_to_ascii_dec_hex_unit.sv */
// Unsigned 32-bit to ASCII text converter, decimal or "0x" + 8 hex digits.
// After acceptance, hex mode registers the prefix and then the digits; decimal mode
// first runs 32 shift-add-3 steps, then skips leading zeros before the first character.
// A new item is taken only in idle, once the last character of the previous one is
// registered; the digit register moves one position per cycle while the output is free.
// Reset (rst, synchronous) empties the output register and returns the controller to idle.
`default_nettype none

// One input beat carries a value and a radix selector. The block answers with
// a run of character beats, most significant character first, with last set
// on the final one. Decimal text has no padding; hex text is always ten
// characters. Internally a controller drives a datapath that holds a 40-bit
// BCD register built by double dabble, so decimal digits come out already in
// printing order. The output register decouples the two sides: a character
// can wait for the consumer while the block already takes the next input.
module unsigned_to_ascii_dec_hex_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output      logic        item_ready,
  input  wire logic [31:0] value,
  input  wire logic        kind,
  output      logic        char_valid,
  input  wire logic        char_ready,
  output      logic [6:0]  character,
  output      logic        last
);
  import u2a_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The controller only sequences; all data stays in the datapath.
  u2a_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .kind       (kind),
    .status     (status),
    .cmd        (cmd)
  );

  u2a_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .value      (value),
    .kind       (kind),
    .cmd        (cmd),
    .status     (status),
    .character  (character),
    .last       (last),
    .char_valid (char_valid),
    .char_ready (char_ready)
  );

endmodule

`default_nettype wire
